/* hdl/rss_pkg.sv */
// rss_pkg: shared types and constants for the running sample statistics block.
// No dependencies; imported by every module of the block.

package rss_pkg;

   localparam int SMP_W   = 16;   // sample field width, Q8.8
   localparam int SQ_W    = 32;   // width of one squared sample
   localparam int OUT_W   = 16;   // width of each numeric result field
   localparam int QDEPTH  = 4;    // front-to-back queue depth
   localparam int QPTR_W  = $clog2(QDEPTH);

   // item kinds carried on req_tuser
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // reset values of the extreme trackers
   localparam logic signed [SMP_W-1:0] MAX_RESET = 16'sh8000;
   localparam logic signed [SMP_W-1:0] MIN_RESET = 16'sh7fff;

   // one classified item as it travels from front to back
   typedef struct packed {
      logic                    kind;
      logic signed [SMP_W-1:0] sample;
      logic [SQ_W-1:0]         square;
   } rss_entry_type;

endpackage

/* hdl/rss_front.sv */
// rss_front: input stage. Takes request beats, sign-extends the sample from its
// significant width and squares it. Depends on rss_pkg.

module rss_front import rss_pkg::*; #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic signed [SMP_W-1:0] req_sample,
   input  logic                    req_kind,
   output logic                    push_valid,
   input  logic                    push_full,
   output rss_entry_type           push_entry
);

   localparam int SB_EFF = (SAMPLE_BITS > SMP_W) ? SMP_W : SAMPLE_BITS;
   localparam int SH     = SMP_W - SB_EFF;

   logic                    vld_ff, vld_in;
   rss_entry_type           ent_ff, ent_in;
   logic signed [SMP_W-1:0] shifted;
   logic signed [SMP_W-1:0] wide;
   logic signed [SQ_W-1:0]  prod;
   logic                    take;
   logic                    push_ok;

   assign shifted = req_sample <<< SH;
   assign wide    = shifted >>> SH;
   assign prod    = wide * wide;

   assign push_ok    = vld_ff && !push_full;
   assign req_tready = !vld_ff || !push_full;
   assign take       = req_tvalid && req_tready;
   assign push_valid = push_ok;
   assign push_entry = ent_ff;

   always_comb begin
      vld_in = vld_ff;
      ent_in = ent_ff;
      if (take) begin
         vld_in        = 1'b1;
         ent_in.kind   = req_kind;
         ent_in.sample = wide;
         ent_in.square = prod;
      end else if (push_ok) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      ent_ff <= ent_in;
   end

endmodule

/* hdl/rss_queue.sv */
// rss_queue: small flop-based FIFO between the front and back stages.
// Depends on rss_pkg for the entry type and depth.

module rss_queue import rss_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  rss_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          empty,
   output rss_entry_type pop_entry
);

   rss_entry_type     q_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign full      = cnt_ff == (QPTR_W+1)'(QDEPTH);
   assign empty     = cnt_ff == '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_entry = q_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         q_ff[wr_ff] <= push_entry;
      end
   end

endmodule

/* hdl/rss_back.sv */
// rss_back: accumulator stage. Pops classified items, tracks extremes, count,
// sum and sum of squares, and hands a snapshot to the report unit. Uses rss_pkg.

module rss_back import rss_pkg::*; #(
   parameter int MAX_SAMPLES = 65536,
   parameter int CNT_W       = 17,
   parameter int SUM_W       = 33,
   parameter int SS_W        = 49
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  rss_entry_type           q_entry,
   output logic                    q_pop,
   input  logic                    rep_busy,
   output logic                    rep_start,
   output logic [CNT_W-1:0]        rep_cnt,
   output logic [SUM_W-1:0]        rep_sum,
   output logic [SS_W-1:0]         rep_ss,
   output logic signed [SMP_W-1:0] rep_max,
   output logic signed [SMP_W-1:0] rep_min,
   output logic                    rep_drop
);

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [SS_W-1:0]         ss_ff, ss_in;
   logic signed [SMP_W-1:0] max_ff, max_in;
   logic signed [SMP_W-1:0] min_ff, min_in;
   logic                    drop_ff, drop_in;
   logic                    is_report;

   assign is_report = q_entry.kind == KIND_REPORT;
   // a report waits until the report unit is free; samples never wait
   assign q_pop     = !q_empty && (!is_report || !rep_busy);
   assign rep_start = q_pop && is_report;

   assign rep_cnt  = cnt_ff;
   assign rep_sum  = sum_ff;
   assign rep_ss   = ss_ff;
   assign rep_max  = max_ff;
   assign rep_min  = min_ff;
   assign rep_drop = drop_ff;

   always_comb begin
      cnt_in  = cnt_ff;
      sum_in  = sum_ff;
      ss_in   = ss_ff;
      max_in  = max_ff;
      min_in  = min_ff;
      drop_in = drop_ff;
      if (rep_start) begin
         cnt_in  = '0;
         sum_in  = '0;
         ss_in   = '0;
         max_in  = MAX_RESET;
         min_in  = MIN_RESET;
         drop_in = 1'b0;
      end else if (q_pop) begin
         if (cnt_ff == CNT_MAX) begin
            drop_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            sum_in = sum_ff + {{(SUM_W-SMP_W){q_entry.sample[SMP_W-1]}}, q_entry.sample};
            ss_in  = ss_ff + {{(SS_W-SQ_W){1'b0}}, q_entry.square};
            if (q_entry.sample > max_ff) begin
               max_in = q_entry.sample;
            end
            if (q_entry.sample < min_ff) begin
               min_in = q_entry.sample;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         sum_ff  <= '0;
         ss_ff   <= '0;
         max_ff  <= MAX_RESET;
         min_ff  <= MIN_RESET;
         drop_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         sum_ff  <= sum_in;
         ss_ff   <= ss_in;
         max_ff  <= max_in;
         min_ff  <= min_in;
         drop_ff <= drop_in;
      end
   end

endmodule

/* hdl/rss_report.sv */
// rss_report: report sequencer. Serial multiply for n*SS - S*S, bit-pair
// square root, shared restoring divider for mean and deviation. Uses rss_pkg.

module rss_report import rss_pkg::*; #(
   parameter int CNT_W = 17,
   parameter int SUM_W = 33,
   parameter int SS_W  = 49
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [CNT_W-1:0]        cnt,
   input  logic [SUM_W-1:0]        sum,
   input  logic [SS_W-1:0]         ss,
   input  logic signed [SMP_W-1:0] max_val,
   input  logic signed [SMP_W-1:0] min_val,
   input  logic                    drop,
   output logic                    busy,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [OUT_W-1:0]        highest,
   output logic [OUT_W-1:0]        lowest,
   output logic [OUT_W-1:0]        spread,
   output logic [OUT_W-1:0]        mean,
   output logic [OUT_W-1:0]        deviation,
   output logic                    empty_res,
   output logic                    overflowed
);

   localparam int V_W    = 2 * SUM_W;
   localparam int STEP_W = $clog2(SUM_W);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MULN = 3'd1;
   localparam logic [2:0] ST_MULS = 3'd2;
   localparam logic [2:0] ST_ROOT = 3'd3;
   localparam logic [2:0] ST_DIVM = 3'd4;
   localparam logic [2:0] ST_DIVD = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [SUM_W-1:0]  mag_ff, mag_in;
   logic              neg_ff, neg_in;
   logic [V_W:0]      acc_ff, acc_in;
   logic [V_W-1:0]    mcand_ff, mcand_in;
   logic [SUM_W-1:0]  mplier_ff, mplier_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  root_ff, root_in;
   logic [SUM_W-1:0]  dvd_ff, dvd_in;
   logic [CNT_W-1:0]  drem_ff, drem_in;
   logic [OUT_W-1:0]  hi_ff, hi_in;
   logic [OUT_W-1:0]  lo_ff, lo_in;
   logic [OUT_W-1:0]  spr_ff, spr_in;
   logic [OUT_W-1:0]  mean_ff, mean_in;
   logic [OUT_W-1:0]  dev_ff, dev_in;
   logic              emp_ff, emp_in;
   logic              ovf_ff, ovf_in;

   logic [SUM_W-1:0]  sum_mag;
   logic [V_W:0]      acc_add;
   logic [V_W:0]      acc_sub;
   logic [V_W:0]      sub_val;
   logic [SUM_W+1:0]  rem_t;
   logic [SUM_W+1:0]  trial;
   logic [SUM_W+1:0]  rem_dif;
   logic              root_ge;
   logic [CNT_W:0]    drem_t;
   logic [CNT_W:0]    drem_dif;
   logic              div_ge;
   logic [SUM_W-1:0]  quot_next;
   logic [SUM_W-1:0]  quot_neg;
   logic              last;

   assign sum_mag = sum[SUM_W-1] ? -sum : sum;
   assign acc_add = acc_ff + {1'b0, mcand_ff};
   assign acc_sub = acc_ff - {1'b0, mcand_ff};
   assign sub_val = mplier_ff[0] ? acc_sub : acc_ff;

   // one root bit per cycle: bring in the next two radicand bits
   assign rem_t   = {rem_ff, acc_ff[V_W-1:V_W-2]};
   assign trial   = {root_ff, 2'b01};
   assign root_ge = rem_t >= trial;
   assign rem_dif = rem_t - trial;

   // restoring divide by the sample count, one quotient bit per cycle
   assign drem_t    = {drem_ff, dvd_ff[SUM_W-1]};
   assign div_ge    = drem_t >= {1'b0, n_ff};
   assign drem_dif  = drem_t - {1'b0, n_ff};
   assign quot_next = {dvd_ff[SUM_W-2:0], div_ge};
   assign quot_neg  = -quot_next;

   assign last = (state_ff == ST_MULN) ? (step_ff == STEP_W'(CNT_W - 1))
                                       : (step_ff == STEP_W'(SUM_W - 1));

   assign busy       = state_ff != ST_IDLE;
   assign rsp_tvalid = state_ff == ST_OUT;
   assign highest    = hi_ff;
   assign lowest     = lo_ff;
   assign spread     = spr_ff;
   assign mean       = mean_ff;
   assign deviation  = dev_ff;
   assign empty_res  = emp_ff;
   assign overflowed = ovf_ff;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      n_in      = n_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      dvd_in    = dvd_ff;
      drem_in   = drem_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      spr_in    = spr_ff;
      mean_in   = mean_ff;
      dev_in    = dev_ff;
      emp_in    = emp_ff;
      ovf_in    = ovf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_in      = cnt;
               neg_in    = sum[SUM_W-1];
               mag_in    = sum_mag;
               hi_in     = max_val;
               lo_in     = min_val;
               ovf_in    = drop;
               acc_in    = '0;
               mcand_in  = {{(V_W-SS_W){1'b0}}, ss};
               mplier_in = {{(SUM_W-CNT_W){1'b0}}, cnt};
               step_in   = '0;
               if (cnt == '0) begin
                  emp_in   = 1'b1;
                  spr_in   = '0;
                  mean_in  = '0;
                  dev_in   = '0;
                  state_in = ST_OUT;
               end else begin
                  emp_in   = 1'b0;
                  spr_in   = max_val - min_val;
                  state_in = ST_MULN;
               end
            end
         end
         ST_MULN: begin
            // acc = n * SS
            if (mplier_ff[0]) begin
               acc_in = acc_add;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff + 1'b1;
            if (last) begin
               mcand_in  = {{(V_W-SUM_W){1'b0}}, mag_ff};
               mplier_in = mag_ff;
               step_in   = '0;
               state_in  = ST_MULS;
            end
         end
         ST_MULS: begin
            // acc -= |S| * |S|; a negative variance clamps to zero
            acc_in    = sub_val;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff + 1'b1;
            if (last) begin
               acc_in   = sub_val[V_W] ? '0 : sub_val;
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            acc_in  = acc_ff << 2;
            rem_in  = root_ge ? rem_dif[SUM_W-1:0] : rem_t[SUM_W-1:0];
            root_in = {root_ff[SUM_W-2:0], root_ge};
            step_in = step_ff + 1'b1;
            if (last) begin
               dvd_in   = mag_ff;
               drem_in  = '0;
               step_in  = '0;
               state_in = ST_DIVM;
            end
         end
         ST_DIVM: begin
            drem_in = div_ge ? drem_dif[CNT_W-1:0] : drem_t[CNT_W-1:0];
            dvd_in  = quot_next;
            step_in = step_ff + 1'b1;
            if (last) begin
               mean_in  = neg_ff ? quot_neg[OUT_W-1:0] : quot_next[OUT_W-1:0];
               dvd_in   = root_ff;
               drem_in  = '0;
               step_in  = '0;
               state_in = ST_DIVD;
            end
         end
         ST_DIVD: begin
            drem_in = div_ge ? drem_dif[CNT_W-1:0] : drem_t[CNT_W-1:0];
            dvd_in  = quot_next;
            step_in = step_ff + 1'b1;
            if (last) begin
               dev_in   = (|quot_next[SUM_W-1:OUT_W]) ? '1 : quot_next[OUT_W-1:0];
               step_in  = '0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      n_ff      <= n_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      dvd_ff    <= dvd_in;
      drem_ff   <= drem_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      spr_ff    <= spr_in;
      mean_ff   <= mean_in;
      dev_ff    <= dev_in;
      emp_ff    <= emp_in;
      ovf_ff    <= ovf_in;
   end

endmodule

/* hdl/running_sample_statistics.sv */
// running_sample_statistics: running min/max/mean/standard deviation over a
// stream of signed Q8.8 samples. Depends on rss_pkg and all rss_* modules.
//
// Request channel (req_*): one beat per item. req_tuser = 0 adds the sample in
// req_tdata to the statistics; req_tuser = 1 asks for a report and clears them.
// Response channel (rsp_*): one beat per report, none per sample.
// Samples are accepted every cycle unless a waiting report backs up the queue.
// The report unit works one bit per cycle through the two serial multiplies,
// the square root and the two divides (CNT_W = clog2(MAX_SAMPLES+1) bits for
// the multiply by n, SUM_W = CNT_W + 16 bits for each other step); an empty
// report skips the math and goes straight to rsp_*.
// The accumulators clear as soon as the report's snapshot is taken, so samples
// after a report keep flowing while the report is computed; a second report
// waits in the four-entry queue until the first has been delivered.
// When rsp_tready is low the result holds on rsp_tdata; a later report then
// blocks the queue head, the queue fills and req_tready drops once it and the
// input register are full.
// Reset (synchronous, active high) empties the queue, clears the statistics
// and drops any report in progress. Samples past MAX_SAMPLES are dropped and
// flagged.

module running_sample_statistics import rss_pkg::*; #(
   parameter int MAX_SAMPLES = 65536,
   parameter int SAMPLE_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,    // [15:0] sample
   input  logic              req_tuser,    // [0] kind
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [79:0]       rsp_tdata,    // highest, lowest, spread, mean, deviation
   output logic [1:0]        rsp_tuser     // [0] empty_res, [1] overflowed
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W = CNT_W + SMP_W;
   localparam int SS_W  = CNT_W + SQ_W;

   logic                    push_valid;
   logic                    q_full;
   rss_entry_type           push_entry;
   logic                    q_pop;
   logic                    q_empty;
   rss_entry_type           q_entry;
   logic                    rep_busy;
   logic                    rep_start;
   logic [CNT_W-1:0]        rep_cnt;
   logic [SUM_W-1:0]        rep_sum;
   logic [SS_W-1:0]         rep_ss;
   logic signed [SMP_W-1:0] rep_max;
   logic signed [SMP_W-1:0] rep_min;
   logic                    rep_drop;
   logic [OUT_W-1:0]        highest;
   logic [OUT_W-1:0]        lowest;
   logic [OUT_W-1:0]        spread;
   logic [OUT_W-1:0]        mean;
   logic [OUT_W-1:0]        deviation;
   logic                    empty_res;
   logic                    overflowed;

   rss_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_sample (req_tdata),
      .req_kind   (req_tuser),
      .push_valid (push_valid),
      .push_full  (q_full),
      .push_entry (push_entry)
   );

   rss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .pop_entry  (q_entry)
   );

   rss_back #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .CNT_W       (CNT_W),
      .SUM_W       (SUM_W),
      .SS_W        (SS_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .rep_busy  (rep_busy),
      .rep_start (rep_start),
      .rep_cnt   (rep_cnt),
      .rep_sum   (rep_sum),
      .rep_ss    (rep_ss),
      .rep_max   (rep_max),
      .rep_min   (rep_min),
      .rep_drop  (rep_drop)
   );

   rss_report #(
      .CNT_W (CNT_W),
      .SUM_W (SUM_W),
      .SS_W  (SS_W)
   ) u_report (
      .clock      (clock),
      .reset      (reset),
      .start      (rep_start),
      .cnt        (rep_cnt),
      .sum        (rep_sum),
      .ss         (rep_ss),
      .max_val    (rep_max),
      .min_val    (rep_min),
      .drop       (rep_drop),
      .busy       (rep_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .highest    (highest),
      .lowest     (lowest),
      .spread     (spread),
      .mean       (mean),
      .deviation  (deviation),
      .empty_res  (empty_res),
      .overflowed (overflowed)
   );

   assign rsp_tdata = {deviation, mean, spread, lowest, highest};
   assign rsp_tuser = {overflowed, empty_res};

endmodule
